/* hw/rtl/mpsa_pkg.sv */
// Package for the multi-pool slot allocator: field widths, command and status codes,
// and the classified request that travels from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package mpsa_pkg;

   localparam int POOLS_DEFAULT = 16;
   localparam int SLOTS_DEFAULT = 1024;

   localparam int CMD_W    = 2;
   localparam int POOL_W   = 4;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOT_USED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2
   } op_kind_type;

   // pool and slot are forced to zero when out of range, so they always index safely
   typedef struct packed {
      op_kind_type         kind;
      logic                pool_ok;
      logic                slot_ok;
      logic [POOL_W-1:0]   pool;
      logic [SLOT_W-1:0]   slot;
   } op_type;

endpackage

/* hw/rtl/mpsa_if.sv */
// Valid/ready channel interfaces for the slot allocator: request and response.
// Depends on mpsa_pkg.
`timescale 1ns / 1ps

interface mpsa_req_if import mpsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [POOL_W-1:0] pool;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, output cmd, output pool, output slot_index, input ready);
   modport sink   (input valid, input cmd, input pool, input slot_index, output ready);
endinterface

interface mpsa_rsp_if import mpsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   granted_slot;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output granted_slot, output free_count,
                   input ready);
   modport sink   (input valid, input status, input granted_slot, input free_count,
                   output ready);
endinterface

/* hw/rtl/multi_pool_slot_allocator_core.sv */
// Multi-pool slot allocator, top level: front end, request queue and back end.
// Depends on mpsa_pkg, mpsa_if, mpsa_front and mpsa_back.
//
// Each pool hands out slot indices first in first out from a ring of free indices and keeps
// an in-use bit per slot; every request (allocate, free, query) returns exactly one
// response carrying a status and the pool's free count. The back end handles each request
// in two states: S_ISSUE reads the ring and in-use memories, and S_EXEC writes them back
// and loads the response register once that register is free, so a new request is taken
// only after the last one is done. Up to two requests queue in the front end while a
// response waits to be taken. After reset the in-use memory is swept clear, one entry per
// cycle, over all POOLS*SLOTS entries (16384 by default); no request is accepted meanwhile.
`timescale 1ns / 1ps

module multi_pool_slot_allocator_core import mpsa_pkg::*; #(
   parameter int POOLS = POOLS_DEFAULT,
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mpsa_req_if.sink   req_if,
   mpsa_rsp_if.source rsp_if
);

   logic   clearing;
   logic   q_valid;
   logic   q_pop;
   op_type q_head;

   mpsa_front #(
      .POOLS (POOLS),
      .SLOTS (SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (!clearing),
      .req_if    (req_if),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   mpsa_back #(
      .POOLS (POOLS),
      .SLOTS (SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_if   (rsp_if)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_pop_spacing: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("back end took requests in consecutive cycles");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_if.ready)
      else $error("request accepted during in-use sweep");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status != ST_OK)) |-> (rsp_if.granted_slot == '0))
      else $error("nonzero granted slot on a failed response");

endmodule

/* hw/rtl/mpsa_front.sv */
// Front end: accepts request transactions, decodes and range-checks them, and holds
// them in a two-entry queue for the back end. Depends on mpsa_pkg and mpsa_if.
`timescale 1ns / 1ps

module mpsa_front import mpsa_pkg::*; #(
   parameter int POOLS = POOLS_DEFAULT,
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept_en,
   mpsa_req_if.sink   req_if,
   output logic       q_valid,
   output op_type     q_head,
   input  logic       q_pop
);

   op_type     q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       acc;
   logic       pool_ok, slot_ok;
   op_type     op_in;

   assign req_if.ready = accept_en && (count_ff != 2'd2);
   assign acc          = req_if.valid && req_if.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_head       = q_ff[rd_ptr_ff];

   always_comb begin
      pool_ok = (32'(req_if.pool) < POOLS);
      slot_ok = (32'(req_if.slot_index) < SLOTS);
      op_in.pool_ok = pool_ok;
      op_in.slot_ok = slot_ok;
      op_in.pool    = pool_ok ? req_if.pool : '0;
      op_in.slot    = slot_ok ? req_if.slot_index : '0;
      case (req_if.cmd)
         CMD_ALLOC: op_in.kind = OP_ALLOC;
         CMD_FREE:  op_in.kind = OP_FREE;
         default:   op_in.kind = OP_QUERY;   // the spare code behaves as a query
      endcase
      count_in = 2'(count_ff + {1'b0, acc} - {1'b0, q_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (acc) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) q_ff[wr_ptr_ff] <= op_in;
   end

endmodule

/* hw/rtl/mpsa_back.sv */
// Back end: per-pool free rings and in-use bits, executed as a read-modify-write across
// the issue and execute states, with the response register. Also runs the in-use clearing
// sweep after reset. Depends on mpsa_pkg and mpsa_if.
`timescale 1ns / 1ps

module mpsa_back import mpsa_pkg::*; #(
   parameter int POOLS = POOLS_DEFAULT,
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   output logic       clearing,
   input  logic       q_valid,
   input  op_type     q_head,
   output logic       q_pop,
   mpsa_rsp_if.source rsp_if
);

   localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_ISSUE = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0] ring_mem [POOLS][SLOTS];
   logic          use_mem  [POOLS][SLOTS];

   logic [SW-1:0] pop_ptr_ff    [POOLS];
   logic [SW-1:0] push_ptr_ff   [POOLS];
   logic [CW-1:0] free_total_ff [POOLS];
   logic          wrapped_ff    [POOLS];

   op_type        op_ff;
   logic [SW-1:0] ring_rd_ff;
   logic          use_rd_ff;
   logic [PW-1:0] clr_pool_ff;
   logic [SW-1:0] clr_slot_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   grant_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic          issue_go, exec_go, clr_last;
   logic [PW-1:0] sel_pool, head_pool, op_pool;
   logic [SW-1:0] head_slot, op_slot;
   logic [SW-1:0] cur_pop, cur_push, pop_next, push_next, ring_val;
   logic [CW-1:0] cur_total;
   logic          cur_wrap, slot_used;
   logic [SW-1:0] pop_in, push_in;
   logic [CW-1:0] total_in;
   logic          wrap_in;
   status_type    status_in;
   logic [SW-1:0] grant_in;
   logic          ring_we;
   logic          use_we;
   logic [PW-1:0] use_wp;
   logic [SW-1:0] use_wa;
   logic          use_wd;
   logic          ex_use_we, ex_use_wd;
   logic [SW-1:0] ex_use_wa;

   assign clearing  = (state_ff == S_CLEAR);
   assign issue_go  = (state_ff == S_ISSUE) && q_valid;
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_if.ready);
   assign q_pop     = issue_go;
   assign clr_last  = (clr_pool_ff == PW'(POOLS - 1)) && (clr_slot_ff == SW'(SLOTS - 1));

   assign head_pool = PW'(q_head.pool);
   assign head_slot = SW'(q_head.slot);
   assign op_pool   = PW'(op_ff.pool);
   assign op_slot   = SW'(op_ff.slot);
   assign sel_pool  = (state_ff == S_EXEC) ? op_pool : head_pool;

   assign cur_pop   = pop_ptr_ff[sel_pool];
   assign cur_push  = push_ptr_ff[sel_pool];
   assign cur_total = free_total_ff[sel_pool];
   assign cur_wrap  = wrapped_ff[sel_pool];

   assign pop_next  = (cur_pop == SW'(SLOTS - 1)) ? '0 : cur_pop + 1'b1;
   assign push_next = (cur_push == SW'(SLOTS - 1)) ? '0 : cur_push + 1'b1;

   // a ring position never pushed to is not read from memory; it stands for its own index
   assign ring_val  = (cur_wrap || (cur_pop < cur_push)) ? ring_rd_ff : cur_pop;
   assign slot_used = op_ff.slot_ok && use_rd_ff;

   always_comb begin
      pop_in    = cur_pop;
      push_in   = cur_push;
      total_in  = cur_total;
      wrap_in   = cur_wrap;
      status_in = ST_OK;
      grant_in  = '0;
      ring_we   = 1'b0;
      ex_use_we = 1'b0;
      ex_use_wa = op_slot;
      ex_use_wd = 1'b0;
      case (op_ff.kind)
         OP_ALLOC: begin
            if (!op_ff.pool_ok || (cur_total == '0)) begin
               status_in = ST_EMPTY;
            end else begin
               grant_in  = ring_val;
               pop_in    = pop_next;
               total_in  = cur_total - 1'b1;
               ex_use_we = 1'b1;
               ex_use_wa = ring_val;
               ex_use_wd = 1'b1;
            end
         end
         OP_FREE: begin
            if (op_ff.pool_ok && slot_used) begin
               ex_use_we = 1'b1;
               // a push onto a full ring is dropped; the in-use bit still clears
               if (32'(cur_total) < SLOTS) begin
                  ring_we  = 1'b1;
                  push_in  = push_next;
                  wrap_in  = cur_wrap || (cur_push == SW'(SLOTS - 1));
                  total_in = cur_total + 1'b1;
               end
            end else begin
               status_in = ST_NOT_USED;
            end
         end
         default: begin
            if (!(op_ff.pool_ok && slot_used)) status_in = ST_NOT_USED;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         use_we = 1'b1;
         use_wp = clr_pool_ff;
         use_wa = clr_slot_ff;
         use_wd = 1'b0;
      end else begin
         use_we = exec_go && ex_use_we;
         use_wp = op_pool;
         use_wa = ex_use_wa;
         use_wd = ex_use_wd;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_last) state_in = S_ISSUE;
         S_ISSUE: if (q_valid) state_in = S_EXEC;
         S_EXEC:  if (exec_go) state_in = S_ISSUE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_pool_ff <= '0;
         clr_slot_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            if (clr_slot_ff == SW'(SLOTS - 1)) begin
               clr_slot_ff <= '0;
               clr_pool_ff <= clr_pool_ff + 1'b1;
            end else begin
               clr_slot_ff <= clr_slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOLS; i++) begin
            pop_ptr_ff[i]    <= '0;
            push_ptr_ff[i]   <= '0;
            free_total_ff[i] <= CW'(SLOTS);
            wrapped_ff[i]    <= 1'b0;
         end
      end else if (exec_go) begin
         pop_ptr_ff[op_pool]    <= pop_in;
         push_ptr_ff[op_pool]   <= push_in;
         free_total_ff[op_pool] <= total_in;
         wrapped_ff[op_pool]    <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_go) op_ff <= q_head;
   end

   always_ff @(posedge clock) begin
      if (exec_go && ring_we) ring_mem[op_pool][cur_push] <= op_slot;
      if (issue_go) ring_rd_ff <= ring_mem[head_pool][cur_pop];
   end

   always_ff @(posedge clock) begin
      if (use_we) use_mem[use_wp][use_wa] <= use_wd;
      if (issue_go) use_rd_ff <= use_mem[head_pool][head_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff <= status_in;
         grant_ff  <= SLOT_W'(grant_in);
         count_ff  <= op_ff.pool_ok ? COUNT_W'(total_in) : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.granted_slot = grant_ff;
   assign rsp_if.free_count   = count_ff;

endmodule

/* tb/multi_pool_slot_allocator_core_tb.sv */
// Self-checking testbench for multi_pool_slot_allocator_core: random valid/ready traffic,
// a transaction-level predictor of every pool's free ring and in-use bits, and a response scoreboard.
// Depends on mpsa_pkg, mpsa_if and the allocator RTL.
`timescale 1ns / 1ps

module multi_pool_slot_allocator_core_tb;
   import mpsa_pkg::*;

   localparam int POOLS        = POOLS_DEFAULT;
   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 780;
   localparam int IDLE_LIMIT   = 4 * POOLS * SLOTS;
   localparam int TAIL_CYCLES  = 16;

   localparam logic [CMD_W-1:0] CMD_QUERY = OP_QUERY;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // undefined code, decoded as a query

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POOL_W-1:0] pool;
      logic [SLOT_W-1:0] slot;
   } slot_request_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  granted;
      logic [COUNT_W-1:0] count;
   } pool_reply_type;

   logic clock;
   logic reset;

   mpsa_req_if req_if ();
   mpsa_rsp_if rsp_if ();

   multi_pool_slot_allocator_core #(
      .POOLS (POOLS),
      .SLOTS (SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // predicted allocator state
   logic [SLOT_W-1:0] ring_slot [POOLS][SLOTS];
   bit                slot_busy [POOLS][SLOTS];
   int unsigned       pop_at    [POOLS];
   int unsigned       push_at   [POOLS];
   int unsigned       free_left [POOLS];

   slot_request_type request_q [$];
   pool_reply_type   reply_q   [$];

   int unsigned issued_n;
   int unsigned accepted_n;
   int unsigned errors;
   int unsigned grants_n, empty_n, rejects_n, frees_n;
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned idle_cycles;
   bit          steady_run;

   function automatic pool_reply_type apply_pool_request(slot_request_type rq);
      pool_reply_type r;
      int unsigned p;
      int unsigned s;
      p = rq.pool;
      s = rq.slot;
      r.status  = ST_OK;
      r.granted = '0;
      r.count   = '0;
      if (p >= POOLS) begin
         r.status = (rq.cmd == CMD_ALLOC) ? ST_EMPTY : ST_NOT_USED;
      end else begin
         if (rq.cmd == CMD_ALLOC) begin
            if (free_left[p] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.granted = ring_slot[p][pop_at[p]];
               pop_at[p] = (pop_at[p] + 1 == SLOTS) ? 0 : pop_at[p] + 1;
               free_left[p]--;
               slot_busy[p][r.granted] = 1'b1;
            end
         end else if (rq.cmd == CMD_FREE) begin
            if (s < SLOTS && slot_busy[p][s]) begin
               slot_busy[p][s] = 1'b0;
               // push onto a full ring is dropped
               if (free_left[p] < SLOTS) begin
                  ring_slot[p][push_at[p]] = SLOT_W'(s);
                  push_at[p] = (push_at[p] + 1 == SLOTS) ? 0 : push_at[p] + 1;
                  free_left[p]++;
               end
            end else begin
               r.status = ST_NOT_USED;
            end
         end else if (!(s < SLOTS && slot_busy[p][s])) begin
            r.status = ST_NOT_USED;
         end
         r.count = COUNT_W'(free_left[p]);
      end
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // any in-use slot of the pool, else a random one
   function automatic int unsigned pick_busy(int unsigned p);
      int unsigned start;
      int unsigned s;
      start = $urandom_range(0, SLOTS - 1);
      for (int unsigned i = 0; i < SLOTS; i++) begin
         s = (start + i) % SLOTS;
         if (slot_busy[p][s]) return s;
      end
      return start;
   endfunction

   task automatic issue(logic [CMD_W-1:0] c, int unsigned p, int unsigned s);
      slot_request_type rq;
      rq.cmd  = c;
      rq.pool = POOL_W'(p);
      rq.slot = SLOT_W'(s);
      request_q.push_back(rq);
      issued_n++;
   endtask

   // wait until every queued request has been accepted, so the predictor is current
   task automatic settle();
      while (accepted_n != issued_n) @(posedge clock);
   endtask

   task automatic drain_all();
      while (accepted_n != issued_n || reply_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      slot_request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (request_q.size() != 0) begin
            rq = request_q.pop_front();
            req_if.valid      <= 1'b1;
            req_if.cmd        <= rq.cmd;
            req_if.pool       <= rq.pool;
            req_if.slot_index <= rq.slot;
            send_gap          <= pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (rsp_if.valid && rsp_if.ready) begin
         g = pick_gap();
         rsp_if.ready <= (g == 0);
         stall_left   <= (g == 0) ? 0 : g - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      slot_request_type rq;
      pool_reply_type   exp_r;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            rq.cmd  = req_if.cmd;
            rq.pool = req_if.pool;
            rq.slot = req_if.slot_index;
            exp_r = apply_pool_request(rq);
            reply_q.push_back(exp_r);
            accepted_n++;
            if (rq.cmd == CMD_ALLOC && exp_r.status == ST_OK) grants_n++;
            if (rq.cmd == CMD_FREE && exp_r.status == ST_OK) frees_n++;
            if (exp_r.status == ST_EMPTY) empty_n++;
            if (exp_r.status == ST_NOT_USED) rejects_n++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: response with nothing outstanding: status %0d slot %0d count %0d",
                        $time, rsp_if.status, rsp_if.granted_slot, rsp_if.free_count);
               errors++;
            end else begin
               exp_r = reply_q.pop_front();
               if (rsp_if.status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                           rsp_if.status);
                  errors++;
               end
               if (rsp_if.granted_slot !== exp_r.granted) begin
                  $display("%0t: granted_slot expected %0d actual %0d", $time, exp_r.granted,
                           rsp_if.granted_slot);
                  errors++;
               end
               if (rsp_if.free_count !== exp_r.count) begin
                  $display("%0t: free_count expected %0d actual %0d", $time, exp_r.count,
                           rsp_if.free_count);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog: the post-reset sweep also counts as idle time
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, %0d requests queued, %0d responses outstanding", $time,
                  request_q.size(), reply_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned rand_sent;
      int unsigned batch;
      int unsigned p;
      int unsigned r;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.cmd        = '0;
      req_if.pool       = '0;
      req_if.slot_index = '0;
      rsp_if.ready      = 1'b0;
      issued_n   = 0;
      accepted_n = 0;
      errors     = 0;
      grants_n   = 0;
      empty_n    = 0;
      rejects_n  = 0;
      frees_n    = 0;
      idle_cycles = 0;
      steady_run  = 1'b0;
      for (int i = 0; i < POOLS; i++) begin
         for (int k = 0; k < SLOTS; k++) begin
            ring_slot[i][k] = SLOT_W'(k);
            slot_busy[i][k] = 1'b0;
         end
         pop_at[i]    = 0;
         push_at[i]   = 0;
         free_left[i] = SLOTS;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, double free, query of idle and busy slots, field extremes
      issue(CMD_ALLOC, 0, 0);
      issue(CMD_ALLOC, 0, SLOTS - 1);
      issue(CMD_QUERY, 0, 0);
      issue(CMD_QUERY, 0, SLOTS - 1);
      issue(CMD_SPARE, 0, 1);
      issue(CMD_SPARE, 0, 512);
      issue(CMD_FREE, 0, 0);
      issue(CMD_FREE, 0, 0);
      issue(CMD_FREE, POOLS - 1, SLOTS - 1);
      issue(CMD_ALLOC, POOLS - 1, 0);
      issue(CMD_QUERY, POOLS - 1, 0);
      issue(CMD_FREE, POOLS - 1, SLOTS - 1);
      issue(CMD_ALLOC, 0, 0);
      issue(CMD_FREE, 0, 1);
      issue(CMD_FREE, 0, 2);
      issue(CMD_QUERY, 0, 1);
      issue(CMD_ALLOC, 7, 0);
      issue(CMD_FREE, 7, 0);
      issue(CMD_QUERY, 7, 0);
      issue(CMD_ALLOC, 0, 0);
      drain_all();

      // random traffic: allocations, frees and queries aimed at slots that are really held, and random commands
      rand_sent = 0;
      while (rand_sent < RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(0, 9) == 0) drain_all();
         steady_run = ($urandom_range(0, 4) == 0);
         batch = $urandom_range(1, 24);
         for (int k = 0; k < batch; k++) begin
            p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, POOLS - 1)
                                            : $urandom_range(0, 3);
            r = $urandom_range(0, 99);
            if (r < 40)
               issue(CMD_ALLOC, p, $urandom_range(0, SLOTS - 1));
            else if (r < 70)
               issue(CMD_FREE, p, pick_busy(p));
            else if (r < 82)
               issue(CMD_QUERY, p, pick_busy(p));
            else
               issue(CMD_W'($urandom_range(1, 3)), p, $urandom_range(0, SLOTS - 1));
            rand_sent++;
         end
      end
      steady_run = 1'b0;

      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions checked: %0d grants, %0d frees, %0d empty-pool, %0d not-in-use",
               accepted_n, grants_n, frees_n, empty_n, rejects_n);
      $display("covered directed command mix, double frees, the spare code and mixed-pool traffic");
      if (errors == 0 && reply_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
